### design/ssc_pkg.sv
// Shared constants for the sphere pair contact pipeline.
package ssc_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int NORM_BITS = 14;
  localparam int NORM_WIDTH = 16;
  localparam int QUOT_BITS = NORM_BITS + 1;
  localparam logic [NORM_WIDTH-1:0] NORM_ONE = NORM_WIDTH'(1 << NORM_BITS);
  // Register stages outside the root and divider pipelines.
  localparam int PIPE_EXTRA = 9;

endpackage

### design/ssc_sqrt.sv
// Pipelined integer square root, one result bit per stage, with a sideband.
module ssc_sqrt #(
  parameter int CW = ssc_pkg::COORD_WIDTH_DEF,
  parameter int SW = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [2*CW-1:0] radicand,
  input  logic [SW-1:0]   in_side,
  output logic            out_valid,
  output logic [CW-1:0]   root,
  output logic [SW-1:0]   out_side
);

  wire            vld_w [0:CW];
  wire [2*CW:0]   rem_w [0:CW];
  wire [CW-1:0]   rt_w  [0:CW];
  wire [SW-1:0]   sd_w  [0:CW];

  assign vld_w[0] = in_valid;
  assign rem_w[0] = {1'b0, radicand};
  assign rt_w[0]  = '0;
  assign sd_w[0]  = in_side;

  for (genvar k = 0; k < CW; k++) begin : g_stage
    localparam int B = CW - 1 - k;
    logic [2*CW:0] inc;
    logic          take;
    logic          v_r;
    logic [2*CW:0] rem_r;
    logic [CW-1:0] rt_r;
    logic [SW-1:0] sd_r;

    // (r + 2^B)^2 - r^2, with the low bits of r still clear.
    assign inc  = ({{(CW+1){1'b0}}, rt_w[k]} << (B + 1)) + ((2*CW+1)'(1) << (2 * B));
    assign take = (inc <= rem_w[k]);

    always_ff @(posedge clk) begin
      if (rst) begin
        v_r <= 1'b0;
      end else begin
        v_r <= vld_w[k];
      end
      rem_r <= take ? rem_w[k] - inc : rem_w[k];
      rt_r  <= take ? (rt_w[k] | (CW'(1) << B)) : rt_w[k];
      sd_r  <= sd_w[k];
    end

    assign vld_w[k+1] = v_r;
    assign rem_w[k+1] = rem_r;
    assign rt_w[k+1]  = rt_r;
    assign sd_w[k+1]  = sd_r;
  end

  assign out_valid = vld_w[CW];
  assign root      = rt_w[CW];
  assign out_side  = sd_w[CW];

endmodule

### design/ssc_div.sv
// Pipelined three-lane restoring divider sharing one divisor, with a sideband.
module ssc_div #(
  parameter int CW = ssc_pkg::COORD_WIDTH_DEF,
  parameter int SW = 8
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       in_valid,
  input  logic [2:0][CW+ssc_pkg::QUOT_BITS-1:0]      num,
  input  logic [CW-1:0]                              den,
  input  logic [SW-1:0]                              in_side,
  output logic                                       out_valid,
  output logic [2:0][ssc_pkg::QUOT_BITS-1:0]         quot,
  output logic [SW-1:0]                              out_side
);

  localparam int QB = ssc_pkg::QUOT_BITS;
  localparam int NW = CW + QB;

  wire                    vld_w [0:QB];
  wire [2:0][NW-1:0]      rem_w [0:QB];
  wire [2:0][QB-1:0]      q_w   [0:QB];
  wire [CW-1:0]           den_w [0:QB];
  wire [SW-1:0]           sd_w  [0:QB];

  assign vld_w[0] = in_valid;
  assign rem_w[0] = num;
  assign q_w[0]   = '0;
  assign den_w[0] = den;
  assign sd_w[0]  = in_side;

  for (genvar k = 0; k < QB; k++) begin : g_stage
    localparam int Q = QB - 1 - k;
    logic [NW-1:0]     sh;
    logic              v_r;
    logic [2:0][NW-1:0] rem_r;
    logic [2:0][QB-1:0] q_r;
    logic [CW-1:0]     den_r;
    logic [SW-1:0]     sd_r;

    assign sh = {{QB{1'b0}}, den_w[k]} << Q;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_r <= 1'b0;
      end else begin
        v_r <= vld_w[k];
      end
      for (int i = 0; i < 3; i++) begin
        if (rem_w[k][i] >= sh) begin
          rem_r[i] <= rem_w[k][i] - sh;
          q_r[i]   <= q_w[k][i] | (QB'(1) << Q);
        end else begin
          rem_r[i] <= rem_w[k][i];
          q_r[i]   <= q_w[k][i];
        end
      end
      den_r <= den_w[k];
      sd_r  <= sd_w[k];
    end

    assign vld_w[k+1] = v_r;
    assign rem_w[k+1] = rem_r;
    assign q_w[k+1]   = q_r;
    assign den_w[k+1] = den_r;
    assign sd_w[k+1]  = sd_r;
  end

  assign out_valid = vld_w[QB];
  assign quot      = q_w[QB];
  assign out_side  = sd_w[QB];

endmodule

### design/sphere_sphere_contact_core.sv
// Sphere pair contact test: fully pipelined top level.
//
// A request is taken at each rising edge where start is high and busy is low.
// busy stays low, so a new sphere pair may be presented in every cycle and the
// block sustains one pair per clock.
// Each request yields exactly one result, shown for one cycle with done high:
// hit, contact point, unit normal (Q1.14) and depth. Without a hit all of the
// other result fields are zero.
// The pipeline holds the square root stages, one root bit per stage, and the
// divider stages that form the normals, one quotient bit per stage, besides
// its own registered stages.
// The receiver cannot stall the block; results leave in request order.
// Synchronous reset clears all valid bits, so no result appears for requests
// in flight at reset. There is no configuration and no state between pairs.
module sphere_sphere_contact_core #(
  parameter int COORD_WIDTH = ssc_pkg::COORD_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  pair_enabled,
  input  logic [COORD_WIDTH-1:0]                center_a_x,
  input  logic [COORD_WIDTH-1:0]                center_a_y,
  input  logic [COORD_WIDTH-1:0]                center_a_z,
  input  logic [COORD_WIDTH-1:0]                center_b_x,
  input  logic [COORD_WIDTH-1:0]                center_b_y,
  input  logic [COORD_WIDTH-1:0]                center_b_z,
  input  logic [COORD_WIDTH-2:0]                radius_a,
  input  logic [COORD_WIDTH-2:0]                radius_b,
  output logic                                  done,
  output logic                                  hit,
  output logic signed [COORD_WIDTH-1:0]         contact_x,
  output logic signed [COORD_WIDTH-1:0]         contact_y,
  output logic signed [COORD_WIDTH-1:0]         contact_z,
  output logic signed [ssc_pkg::NORM_WIDTH-1:0] normal_x,
  output logic signed [ssc_pkg::NORM_WIDTH-1:0] normal_y,
  output logic signed [ssc_pkg::NORM_WIDTH-1:0] normal_z,
  output logic [COORD_WIDTH-1:0]                depth
);

  localparam int CW  = COORD_WIDTH;
  localparam int QB  = ssc_pkg::QUOT_BITS;
  localparam int NB  = ssc_pkg::NORM_BITS;
  localparam int NWD = ssc_pkg::NORM_WIDTH;
  localparam int LAT = CW + QB + ssc_pkg::PIPE_EXTRA;
  localparam int SW1 = 8 * CW + 4;
  localparam int SW2 = 5 * CW + 4;

  logic accept;
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  logic [CW-1:0] ca_in [3];
  logic [CW-1:0] cb_in [3];
  assign ca_in[0] = center_a_x;
  assign ca_in[1] = center_a_y;
  assign ca_in[2] = center_a_z;
  assign cb_in[0] = center_b_x;
  assign cb_in[1] = center_b_y;
  assign cb_in[2] = center_b_z;

  // Stage 1: differences.
  logic          v1, en1;
  logic [CW-1:0] ca1 [3];
  logic [CW:0]   d1 [3];
  logic [CW-2:0] ra1, rb1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
    en1 <= pair_enabled;
    ra1 <= radius_a;
    rb1 <= radius_b;
    for (int i = 0; i < 3; i++) begin
      ca1[i] <= ca_in[i];
      d1[i]  <= {ca_in[i][CW-1], ca_in[i]} - {cb_in[i][CW-1], cb_in[i]};
    end
  end

  // Stage 2: magnitudes and radius sum.
  logic          v2, en2;
  logic [CW-1:0] ca2 [3];
  logic [CW:0]   ad2 [3];
  logic [2:0]    sg2;
  logic [CW-1:0] rs2;
  logic [CW-2:0] ra2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    en2 <= en1;
    ra2 <= ra1;
    rs2 <= {1'b0, ra1} + {1'b0, rb1};
    for (int i = 0; i < 3; i++) begin
      ca2[i] <= ca1[i];
      sg2[i] <= d1[i][CW];
      ad2[i] <= d1[i][CW] ? (~d1[i] + 1'b1) : d1[i];
    end
  end

  // Stage 3: squares.
  logic            v3, en3;
  logic [CW-1:0]   ca3 [3];
  logic [CW-1:0]   ad3 [3];
  logic [2*CW+1:0] sq3 [3];
  logic [2:0]      sg3;
  logic [CW-1:0]   rs3;
  logic [CW-2:0]   ra3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    en3 <= en2;
    ra3 <= ra2;
    rs3 <= rs2;
    sg3 <= sg2;
    for (int i = 0; i < 3; i++) begin
      ca3[i] <= ca2[i];
      ad3[i] <= ad2[i][CW-1:0];
      sq3[i] <= ad2[i] * ad2[i];
    end
  end

  // Stage 4: squared distance and squared radius sum.
  logic            v4, en4;
  logic [CW-1:0]   ca4 [3];
  logic [CW-1:0]   ad4 [3];
  logic [2*CW+1:0] sum4;
  logic [2*CW-1:0] rsq4;
  logic [2:0]      sg4;
  logic [CW-1:0]   rs4;
  logic [CW-2:0]   ra4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    en4  <= en3;
    ra4  <= ra3;
    rs4  <= rs3;
    sg4  <= sg3;
    sum4 <= sq3[0] + sq3[1] + sq3[2];
    rsq4 <= rs3 * rs3;
    for (int i = 0; i < 3; i++) begin
      ca4[i] <= ca3[i];
      ad4[i] <= ad3[i];
    end
  end

  // Stage 5: overlap decision.
  logic            v5, hit5, zero5;
  logic [CW-1:0]   ca5 [3];
  logic [CW-1:0]   ad5 [3];
  logic [2*CW-1:0] rad5;
  logic [2:0]      sg5;
  logic [CW-1:0]   rs5;
  logic [CW-2:0]   ra5;
  logic            zero4;

  assign zero4 = (sum4 == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
    zero5 <= zero4;
    hit5  <= en4 & (zero4 | ({2'b00, rsq4} > sum4));
    rad5  <= sum4[2*CW-1:0];
    ra5   <= ra4;
    rs5   <= rs4;
    sg5   <= sg4;
    for (int i = 0; i < 3; i++) begin
      ca5[i] <= ca4[i];
      ad5[i] <= ad4[i];
    end
  end

  // Square root pipeline.
  logic [SW1-1:0] side5, side6;
  logic           v6, hit6, zero6;
  logic [CW-1:0]  len6;
  logic [CW-1:0]  ca6 [3];
  logic [CW-1:0]  ad6 [3];
  logic [2:0]     sg6;
  logic [CW-1:0]  rs6;
  logic [CW-2:0]  ra6;

  assign side5 = {hit5, zero5, ca5[0], ca5[1], ca5[2], ad5[0], ad5[1], ad5[2], sg5, rs5, ra5};
  assign {hit6, zero6, ca6[0], ca6[1], ca6[2], ad6[0], ad6[1], ad6[2], sg6, rs6, ra6} = side6;

  ssc_sqrt #(
    .CW (CW),
    .SW (SW1)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v5),
    .radicand  (rad5),
    .in_side   (side5),
    .out_valid (v6),
    .root      (len6),
    .out_side  (side6)
  );

  // Stage 7: depth and rounded normal numerators.
  logic                   v7, hit7, zero7;
  logic [2:0][CW+QB-1:0]  num7;
  logic [CW-1:0]          len7;
  logic [CW-1:0]          dep7;
  logic [CW-1:0]          ca7 [3];
  logic [2:0]             sg7;
  logic [CW-2:0]          ra7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else begin
      v7 <= v6;
    end
    hit7  <= hit6;
    zero7 <= zero6;
    len7  <= len6;
    dep7  <= rs6 - len6;
    sg7   <= sg6;
    ra7   <= ra6;
    for (int i = 0; i < 3; i++) begin
      ca7[i]  <= ca6[i];
      num7[i] <= {1'b0, ad6[i], {NB{1'b0}}} + {{(QB+1){1'b0}}, len6[CW-1:1]};
    end
  end

  // Divider pipeline.
  logic [SW2-1:0]       side7, side8;
  logic                 v8, hit8, zero8;
  logic [2:0][QB-1:0]   m8;
  logic [CW-1:0]        ca8 [3];
  logic [2:0]           sg8;
  logic [CW-1:0]        dep8;
  logic [CW-2:0]        ra8;

  assign side7 = {hit7, zero7, ca7[0], ca7[1], ca7[2], sg7, dep7, ra7};
  assign {hit8, zero8, ca8[0], ca8[1], ca8[2], sg8, dep8, ra8} = side8;

  ssc_div #(
    .CW (CW),
    .SW (SW2)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v7),
    .num       (num7),
    .den       (len7),
    .in_side   (side7),
    .out_valid (v8),
    .quot      (m8),
    .out_side  (side8)
  );

  // Stage 9: normal times depth.
  logic              v9, hit9, zero9;
  logic [QB+CW-1:0]  prod9 [3];
  logic [QB-1:0]     m9 [3];
  logic [CW-1:0]     ca9 [3];
  logic [2:0]        sg9;
  logic [CW-1:0]     dep9;
  logic [CW-2:0]     ra9;

  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else begin
      v9 <= v8;
    end
    hit9  <= hit8;
    zero9 <= zero8;
    sg9   <= sg8;
    dep9  <= dep8;
    ra9   <= ra8;
    for (int i = 0; i < 3; i++) begin
      ca9[i]   <= ca8[i];
      m9[i]    <= m8[i];
      prod9[i] <= m8[i] * dep8;
    end
  end

  // Stage 10: rounded offset applied to the first center.
  logic              v10, hit10, zero10;
  logic [CW+1:0]     ct10 [3];
  logic [NWD-1:0]    n10 [3];
  logic [CW-1:0]     ca10 [3];
  logic [CW-1:0]     dep10;
  logic [CW-2:0]     ra10;
  logic [QB+CW-1:0]  rnd [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd[i] = prod9[i] + ((QB+CW)'(1) << (NB - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v10 <= 1'b0;
    end else begin
      v10 <= v9;
    end
    hit10  <= hit9;
    zero10 <= zero9;
    dep10  <= dep9;
    ra10   <= ra9;
    for (int i = 0; i < 3; i++) begin
      ca10[i] <= ca9[i];
      n10[i]  <= sg9[i] ? (~{1'b0, m9[i]} + 1'b1) : {1'b0, m9[i]};
      if (sg9[i]) begin
        ct10[i] <= {{2{ca9[i][CW-1]}}, ca9[i]} - {1'b0, rnd[i][QB+CW-1:NB]};
      end else begin
        ct10[i] <= {{2{ca9[i][CW-1]}}, ca9[i]} + {1'b0, rnd[i][QB+CW-1:NB]};
      end
    end
  end

  // Stage 11: saturation and result selection.
  logic signed [CW+1:0] sat_hi, sat_lo;
  logic [CW-1:0]        ct_sat [3];
  logic [CW-1:0]        ct_out [3];
  logic [NWD-1:0]       n_out [3];
  logic [CW-1:0]        dep_out;

  assign sat_hi = $signed({3'b000, {(CW-1){1'b1}}});
  assign sat_lo = $signed({3'b111, {(CW-1){1'b0}}});

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if ($signed(ct10[i]) > sat_hi) begin
        ct_sat[i] = sat_hi[CW-1:0];
      end else if ($signed(ct10[i]) < sat_lo) begin
        ct_sat[i] = sat_lo[CW-1:0];
      end else begin
        ct_sat[i] = ct10[i][CW-1:0];
      end
      if (!hit10) begin
        ct_out[i] = '0;
        n_out[i]  = '0;
      end else if (zero10) begin
        ct_out[i] = ca10[i];
        n_out[i]  = (i == 0) ? ssc_pkg::NORM_ONE : '0;
      end else begin
        ct_out[i] = ct_sat[i];
        n_out[i]  = n10[i];
      end
    end
    if (!hit10) begin
      dep_out = '0;
    end else if (zero10) begin
      dep_out = {1'b0, ra10};
    end else begin
      dep_out = dep10;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      hit  <= 1'b0;
    end else begin
      done <= v10;
      hit  <= v10 & hit10;
    end
    contact_x <= ct_out[0];
    contact_y <= ct_out[1];
    contact_z <= ct_out[2];
    normal_x  <= n_out[0];
    normal_y  <= n_out[1];
    normal_z  <= n_out[2];
    depth     <= dep_out;
  end

  // Every request comes out after exactly the pipeline latency.
  a_latency: assert property (@(posedge clk) disable iff (rst) accept |-> ##LAT done)
    else $error("request did not produce a result after the pipeline latency");

  a_hit_done: assert property (@(posedge clk) disable iff (rst) hit |-> done)
    else $error("hit raised without a result strobe");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !hit) |-> (depth == '0 && contact_x == '0 && normal_x == '0 && normal_y == '0))
    else $error("result fields not cleared on a miss");

  a_norm_range: assert property (@(posedge clk) disable iff (rst)
    (done && hit) |-> (normal_x <= $signed(ssc_pkg::NORM_ONE) &&
                       normal_x >= -$signed(ssc_pkg::NORM_ONE)))
    else $error("normal component out of unit range");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(v10))
    else $error("result strobe without an item in the last stage");

endmodule

### tb/sv/tb_sphere_sphere_contact_core.sv
// Self-checking testbench for the sphere pair contact pipeline.
module tb_sphere_sphere_contact_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = ssc_pkg::COORD_WIDTH_DEF;
  localparam int NB = ssc_pkg::NORM_BITS;
  localparam int LATENCY = CW + 24;
  localparam longint MAX_CYCLES = 400000;

  typedef struct packed {
    logic hit;
    logic [CW-1:0] cx, cy, cz;
    logic [15:0] nx, ny, nz;
    logic [CW-1:0] dep;
  } contact_t;

  class contact_scoreboard;
    contact_t pending[$];
    int errors;

    function automatic logic [63:0] root128(logic [127:0] v);
      logic [63:0] r, t;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
        t = r | (64'd1 << b);
        if ({64'd0, t} * {64'd0, t} <= v) r = t;
      end
      return r;
    endfunction

    function automatic void note_request(logic en, logic [CW-1:0] a[3], logic [CW-1:0] b[3],
                                         logic [CW-2:0] ra, logic [CW-2:0] rb);
      contact_t c;
      longint d[3];
      longint ca;
      logic [63:0] ad, len, rs, m, off;
      logic [127:0] sum;
      longint v;
      c = '0;
      sum = '0;
      rs = {33'd0, ra} + {33'd0, rb};
      for (int i = 0; i < 3; i++) begin
        d[i] = longint'($signed(a[i])) - longint'($signed(b[i]));
        ad = d[i] < 0 ? -d[i] : d[i];
        sum += {64'd0, ad} * {64'd0, ad};
      end
      if (en) begin
        if (sum == 0) begin
          c.hit = 1'b1;
          c.nx = ssc_pkg::NORM_ONE;
          c.dep = CW'(ra);
          c.cx = a[0]; c.cy = a[1]; c.cz = a[2];
        end else if ({64'd0, rs} * {64'd0, rs} > sum) begin
          len = root128(sum);
          c.hit = 1'b1;
          c.dep = CW'(rs - len);
          for (int i = 0; i < 3; i++) begin
            ad = d[i] < 0 ? -d[i] : d[i];
            m = ((ad << NB) + (len >> 1)) / len;
            off = (m * (rs - len) + (64'd1 << (NB - 1))) >> NB;
            ca = longint'($signed(a[i]));
            v = d[i] < 0 ? ca - longint'(off) : ca + longint'(off);
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            if (i == 0) begin c.nx = d[i] < 0 ? -m[15:0] : m[15:0]; c.cx = v[CW-1:0]; end
            if (i == 1) begin c.ny = d[i] < 0 ? -m[15:0] : m[15:0]; c.cy = v[CW-1:0]; end
            if (i == 2) begin c.nz = d[i] < 0 ? -m[15:0] : m[15:0]; c.cz = v[CW-1:0]; end
          end
        end
      end
      pending.push_back(c);
    endfunction

    function automatic void check_result(contact_t got);
      contact_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.hit !== e.hit) report("hit", 64'(e.hit), 64'(got.hit));
      if (got.cx !== e.cx) report("contact_x", 64'(e.cx), 64'(got.cx));
      if (got.cy !== e.cy) report("contact_y", 64'(e.cy), 64'(got.cy));
      if (got.cz !== e.cz) report("contact_z", 64'(e.cz), 64'(got.cz));
      if (got.nx !== e.nx) report("normal_x", 64'(e.nx), 64'(got.nx));
      if (got.ny !== e.ny) report("normal_y", 64'(e.ny), 64'(got.ny));
      if (got.nz !== e.nz) report("normal_z", 64'(e.nz), 64'(got.nz));
      if (got.dep !== e.dep) report("depth", 64'(e.dep), 64'(got.dep));
    endfunction

    function automatic void report(string f, logic [63:0] e, logic [63:0] g);
      $display("%0t: %s mismatch, expected %h, actual %h", $time, f, e, g);
      errors++;
    endfunction
  endclass

  logic clk = 1'b0, rst = 1'b1, start = 1'b0, busy, done, hit, pair_enabled = 1'b0;
  logic [CW-1:0] center_a_x = '0, center_a_y = '0, center_a_z = '0;
  logic [CW-1:0] center_b_x = '0, center_b_y = '0, center_b_z = '0;
  logic [CW-2:0] radius_a = '0, radius_b = '0;
  logic signed [CW-1:0] contact_x, contact_y, contact_z;
  logic signed [15:0] normal_x, normal_y, normal_z;
  logic [CW-1:0] depth;
  longint cycles = 0;
  contact_scoreboard contacts = new();

  sphere_sphere_contact_core uut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && start && !busy)
      contacts.note_request(pair_enabled, '{center_a_x, center_a_y, center_a_z},
                            '{center_b_x, center_b_y, center_b_z}, radius_a, radius_b);
    if (!rst && done)
      contacts.check_result({hit, contact_x, contact_y, contact_z,
                             normal_x, normal_y, normal_z, depth});
    if (cycles > MAX_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Holds one request until accepted, then leaves start high for a follow-on.
  task automatic send_pair(logic en, logic [CW-1:0] a[3], logic [CW-1:0] b[3],
                           logic [CW-2:0] ra, logic [CW-2:0] rb);
    start <= 1'b1;
    pair_enabled <= en;
    center_a_x <= a[0]; center_a_y <= a[1]; center_a_z <= a[2];
    center_b_x <= b[0]; center_b_y <= b[1]; center_b_z <= b[2];
    radius_a <= ra; radius_b <= rb;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 80) : $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  function automatic logic [CW-1:0] rnd_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return CW'($signed($urandom_range(0, 2000000)) - 1000000);
      default: return CW'($signed($urandom_range(0, 400)) - 200);
    endcase
  endfunction

  task automatic random_pair();
    logic [CW-1:0] a[3], b[3];
    logic [CW-2:0] ra, rb;
    int mode;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) begin
      a[i] = rnd_coord(mode == 0 ? 0 : 1);
      // Most pairs sit close so that overlaps are common.
      b[i] = (mode < 2) ? rnd_coord(mode == 0 ? 0 : 1) : a[i] + rnd_coord(mode < 5 ? 1 : 2);
    end
    if (mode == 9) b = a;
    case ($urandom_range(0, 4))
      0: begin ra = (CW-1)'($urandom()); rb = (CW-1)'($urandom()); end
      1: begin
        ra = (CW-1)'($urandom_range(0, 100));
        rb = (CW-1)'($urandom_range(0, 100));
      end
      default: begin
        ra = (CW-1)'($urandom_range(0, 3000000));
        rb = (CW-1)'($urandom_range(0, 3000000));
      end
    endcase
    send_pair($urandom_range(0, 7) != 0, a, b, ra, rb);
  endtask

  initial begin
    logic [CW-1:0] mx, mn, z;
    mx = {1'b0, {(CW-1){1'b1}}};
    mn = {1'b1, {(CW-1){1'b0}}};
    z = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // Directed: disabled pair, coincident centres with zero radii, axis normals,
    // extreme coordinates and radii, saturating contacts, touching exactly.
    send_pair(1'b0, '{z, z, z}, '{z, z, z}, '1, '1);
    send_pair(1'b1, '{z, z, z}, '{z, z, z}, '0, '0);
    send_pair(1'b1, '{mx, mn, mx}, '{mx, mn, mx}, '1, '0);
    send_pair(1'b1, '{32'h10000, z, z}, '{z, z, z}, 31'h10000, 31'h10000);
    send_pair(1'b1, '{z, 32'hffff0000, z}, '{z, z, z}, 31'h8000, 31'h10000);
    send_pair(1'b1, '{z, z, 32'h30000}, '{z, z, z}, 31'h10000, 31'h20000);
    send_pair(1'b1, '{mx, mx, mx}, '{mn, mn, mn}, '1, '1);
    send_pair(1'b1, '{mn, mn, mn}, '{mx, mx, mx}, '1, '1);
    send_pair(1'b1, '{mx, z, z}, '{mx - 32'd5, z, z}, '1, '1);
    send_pair(1'b1, '{mn, z, z}, '{mn + 32'd5, z, z}, '1, '1);
    send_pair(1'b1, '{32'd1, 32'd1, 32'd1}, '{z, z, z}, 31'd1, 31'd1);
    send_pair(1'b1, '{32'd3, 32'hfffffffc, z}, '{z, z, z}, 31'd7, 31'd0);
    send_pair(1'b0, '{32'd3, 32'd4, z}, '{z, z, z}, 31'd7, 31'd0);
    send_pair(1'b1, '{32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa},
              '{32'h55555555, 32'haaaaaaaa, 32'h55555555}, '1, '1);
    for (int k = 0; k < 1200; k++) begin
      idle_gap();
      if (k == 600) begin
        start <= 1'b0;
        @(negedge clk);
        while (contacts.pending.size() != 0) @(negedge clk);
      end
      random_pair();
    end
    start <= 1'b0;
    while (contacts.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    if (contacts.errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
